[hw/rtl/voxel_line_rasterizer_assert.svh]
// ----------------------------------------------------------------------------
// voxel line rasterizer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef VOXEL_LINE_RASTERIZER_ASSERT_SVH
`define VOXEL_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define VLR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VLR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vlr_pkg.sv]
// ----------------------------------------------------------------------------
// vlr_pkg
// types, constants and helpers for the voxel line rasterizer
// ----------------------------------------------------------------------------
package vlr_pkg;

    localparam int CUBE_EDGE = 8;
    localparam int COORD_W   = 3;
    localparam int IDX_W     = 9;
    localparam int COLOR_W   = 8;
    localparam int ERR_W     = COORD_W + 3;
    localparam int NUM_AXES  = 3;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic               neg;
        logic [COORD_W-1:0] mag;
        logic [ERR_W-1:0]   err;
    } axis_st_t;

    typedef axis_st_t [NUM_AXES-1:0] axes_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        if (int'(v) > CUBE_EDGE - 1) begin
            return COORD_W'(CUBE_EDGE - 1);
        end
        return v;
    endfunction

endpackage

[hw/rtl/vlr_step_unit.sv]
// ----------------------------------------------------------------------------
// vlr_step_unit
// one bresenham step: moves the major axis and updates minor error terms
// ----------------------------------------------------------------------------
module vlr_step_unit
    import vlr_pkg::*;
(
    input  axes_t              axes_in,
    input  axis_t              major,
    input  logic [COORD_W-1:0] steps,
    output axes_t              axes_out
);

    always_comb begin
        axes_out = axes_in;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (int'(major) == a) begin
                axes_out[a].pos = axes_in[a].pos
                                + (axes_in[a].neg ? {COORD_W{1'b1}} : COORD_W'(1));
            end else begin
                if ($signed(axes_in[a].err) > 0) begin
                    axes_out[a].pos = axes_in[a].pos
                                    + (axes_in[a].neg ? {COORD_W{1'b1}} : COORD_W'(1));
                    axes_out[a].err = axes_in[a].err - ERR_W'({steps, 1'b0})
                                    + ERR_W'({axes_in[a].mag, 1'b0});
                end else begin
                    axes_out[a].err = axes_in[a].err + ERR_W'({axes_in[a].mag, 1'b0});
                end
            end
        end
    end

endmodule

[hw/rtl/vlr_led_map.sv]
// ----------------------------------------------------------------------------
// vlr_led_map
// maps voxel coordinates to a strip index, plain or serpentine wiring
// ----------------------------------------------------------------------------
module vlr_led_map
    import vlr_pkg::*;
(
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic [COORD_W-1:0] z,
    input  logic               serpentine,
    output logic [IDX_W-1:0]   led_index
);

    logic [IDX_W-1:0] xm;
    logic [IDX_W-1:0] zm;

    always_comb begin
        xm = IDX_W'(x);
        zm = IDX_W'(z);
        if (serpentine) begin
            if (x[0] && y[0]) begin
                zm = IDX_W'(CUBE_EDGE - 1) - IDX_W'(z);
            end
            if (y[0]) begin
                xm = IDX_W'(CUBE_EDGE - 1) - IDX_W'(x);
            end
        end
        led_index = IDX_W'(y) * IDX_W'(CUBE_EDGE * CUBE_EDGE)
                  + xm * IDX_W'(CUBE_EDGE) + zm;
    end

endmodule

[hw/rtl/voxel_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// voxel_line_rasterizer
// walks a 3d bresenham line through the cube, one voxel item per step
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    start and end points, colour
// m_       out        m_valid / m_ready    voxel coordinates, led index, colour, last
// cfg_     in         cfg_valid/cfg_ready  serpentine_mapping
//
// a line of n voxels (n = largest axis delta + 1, up to 8) is accepted, then
// its deltas and error terms are set up, then it walks one voxel per cycle
// from the shared step unit. the next item is accepted once the last voxel is
// in the output register. reset is synchronous; serpentine mapping resets to 1.
// a stalled output holds the walk; cfg_ready is always high.
// ----------------------------------------------------------------------------
module voxel_line_rasterizer
    import vlr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_serpentine_mapping,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_start_x,
    input  logic [COORD_W-1:0] s_start_y,
    input  logic [COORD_W-1:0] s_start_z,
    input  logic [COORD_W-1:0] s_end_x,
    input  logic [COORD_W-1:0] s_end_y,
    input  logic [COORD_W-1:0] s_end_z,
    input  logic [COLOR_W-1:0] s_red,
    input  logic [COLOR_W-1:0] s_green,
    input  logic [COLOR_W-1:0] s_blue,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_voxel_x,
    output logic [COORD_W-1:0] m_voxel_y,
    output logic [COORD_W-1:0] m_voxel_z,
    output logic [IDX_W-1:0]   m_led_index,
    output logic [COLOR_W-1:0] m_out_red,
    output logic [COLOR_W-1:0] m_out_green,
    output logic [COLOR_W-1:0] m_out_blue,
    output logic               m_last_voxel
);

    state_t             state_reg,    state_next;
    logic               serp_reg;
    axes_t              axes_reg,     axes_next;
    logic [COORD_W-1:0] end_reg [NUM_AXES];
    logic [COORD_W-1:0] end_next [NUM_AXES];
    logic [COLOR_W-1:0] red_reg,      red_next;
    logic [COLOR_W-1:0] green_reg,    green_next;
    logic [COLOR_W-1:0] blue_reg,     blue_next;
    axis_t              major_reg,    major_next;
    logic [COORD_W-1:0] steps_reg,    steps_next;
    logic [COORD_W-1:0] remain_reg,   remain_next;

    logic               m_valid_reg,  m_valid_next;
    logic [COORD_W-1:0] vx_reg,       vx_next;
    logic [COORD_W-1:0] vy_reg,       vy_next;
    logic [COORD_W-1:0] vz_reg,       vz_next;
    logic [IDX_W-1:0]   led_reg,      led_next;
    logic [COLOR_W-1:0] ored_reg,     ored_next;
    logic [COLOR_W-1:0] ogreen_reg,   ogreen_next;
    logic [COLOR_W-1:0] oblue_reg,    oblue_next;
    logic               last_reg,     last_next;

    axes_t              axes_step;
    logic [IDX_W-1:0]   led_cur;

    vlr_step_unit u_step (
        .axes_in  (axes_reg),
        .major    (major_reg),
        .steps    (steps_reg),
        .axes_out (axes_step)
    );

    vlr_led_map u_led_map (
        .x          (axes_reg[AXIS_X].pos),
        .y          (axes_reg[AXIS_Y].pos),
        .z          (axes_reg[AXIS_Z].pos),
        .serpentine (serp_reg),
        .led_index  (led_cur)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serp_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            serp_reg <= cfg_serpentine_mapping;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        axes_reg   <= axes_next;
        end_reg    <= end_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        major_reg  <= major_next;
        steps_reg  <= steps_next;
        remain_reg <= remain_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        vz_reg     <= vz_next;
        led_reg    <= led_next;
        ored_reg   <= ored_next;
        ogreen_reg <= ogreen_next;
        oblue_reg  <= oblue_next;
        last_reg   <= last_next;
    end

    always_comb begin
        logic [COORD_W:0]   d;
        logic [COORD_W-1:0] mag_v [NUM_AXES];
        logic               neg_v [NUM_AXES];
        axis_t              major_v;
        logic [COORD_W-1:0] steps_v;

        state_next   = state_reg;
        axes_next    = axes_reg;
        end_next     = end_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        major_next   = major_reg;
        steps_next   = steps_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        vz_next      = vz_reg;
        led_next     = led_reg;
        ored_next    = ored_reg;
        ogreen_next  = ogreen_reg;
        oblue_next   = oblue_reg;
        last_next    = last_reg;
        s_ready      = 1'b0;
        d            = '0;
        major_v      = AXIS_X;
        steps_v      = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            mag_v[a] = '0;
            neg_v[a] = 1'b0;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    axes_next[AXIS_X].pos = clamp_coord(s_start_x);
                    axes_next[AXIS_Y].pos = clamp_coord(s_start_y);
                    axes_next[AXIS_Z].pos = clamp_coord(s_start_z);
                    end_next[AXIS_X]      = clamp_coord(s_end_x);
                    end_next[AXIS_Y]      = clamp_coord(s_end_y);
                    end_next[AXIS_Z]      = clamp_coord(s_end_z);
                    red_next              = s_red;
                    green_next            = s_green;
                    blue_next             = s_blue;
                    state_next            = ST_SETUP;
                end
            end
            ST_SETUP: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    d        = {1'b0, end_reg[a]} - {1'b0, axes_reg[a].pos};
                    neg_v[a] = d[COORD_W];
                    mag_v[a] = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
                end
                if (mag_v[AXIS_X] >= mag_v[AXIS_Y] && mag_v[AXIS_X] >= mag_v[AXIS_Z]) begin
                    major_v = AXIS_X;
                    steps_v = mag_v[AXIS_X];
                end else if (mag_v[AXIS_Y] >= mag_v[AXIS_Z]) begin
                    major_v = AXIS_Y;
                    steps_v = mag_v[AXIS_Y];
                end else begin
                    major_v = AXIS_Z;
                    steps_v = mag_v[AXIS_Z];
                end
                for (int a = 0; a < NUM_AXES; a++) begin
                    axes_next[a].neg = neg_v[a];
                    axes_next[a].mag = mag_v[a];
                    axes_next[a].err = ERR_W'({mag_v[a], 1'b0}) - ERR_W'(steps_v);
                end
                major_next  = major_v;
                steps_next  = steps_v;
                remain_next = steps_v;
                state_next  = ST_WALK;
            end
            ST_WALK: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    vx_next      = axes_reg[AXIS_X].pos;
                    vy_next      = axes_reg[AXIS_Y].pos;
                    vz_next      = axes_reg[AXIS_Z].pos;
                    led_next     = led_cur;
                    ored_next    = red_reg;
                    ogreen_next  = green_reg;
                    oblue_next   = blue_reg;
                    last_next    = (remain_reg == '0);
                    if (remain_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        axes_next   = axes_step;
                        remain_next = remain_reg - COORD_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_voxel_x    = vx_reg;
    assign m_voxel_y    = vy_reg;
    assign m_voxel_z    = vz_reg;
    assign m_led_index  = led_reg;
    assign m_out_red    = ored_reg;
    assign m_out_green  = ogreen_reg;
    assign m_out_blue   = oblue_reg;
    assign m_last_voxel = last_reg;

endmodule

[hw/rtl/vlr_checker.sv]
// ----------------------------------------------------------------------------
// vlr_checker
// port-level checks on the voxel line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "voxel_line_rasterizer_assert.svh"

module vlr_checker
    import vlr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_last_voxel,
    input logic [IDX_W-1:0] m_led_index
);

    // stalled voxel item holds
    `VLR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_led_index), "stalled voxel item changed")

    // a new line is not taken in the cycle after one is accepted
    `VLR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after accept")

    // voxels of one line follow without gaps
    `VLR_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_last_voxel, m_valid, "gap inside a line")

    // no new line while a line is still being walked
    `VLR_ASSERT_NOW(a_busy_mid_line, aclk, aresetn, m_valid && !m_last_voxel, !s_ready, "input ready mid line")

endmodule

bind voxel_line_rasterizer vlr_checker u_vlr_checker (.*);
